// File: rtl/obbsat_pkg.sv
// Shared constants and types for the oriented-box separating-axis test.
`default_nettype none
package obbsat_pkg;

   // Request command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   // Field widths
   localparam int POS_W  = 24;
   localparam int AXIS_W = 16;
   localparam int SIZE_W = 12;
   localparam int SCL_W  = 16;
   localparam int DIFF_W = POS_W + 1;
   localparam int HALF_W = SIZE_W + SCL_W;

   // Shared multiplier and accumulators
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = HALF_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DOT_W   = 43;
   localparam int MAG_W   = 41;
   localparam int RAD_W   = 62;
   localparam int SHIFT_W = 15;

   // Accumulator controls from the sequencer to the multiply unit
   typedef struct packed {
      logic dot_load;
      logic dot_add;
      logic rad_load;
      logic rad_add;
   } mac_ctrl_type;

endpackage
`default_nettype wire

// File: rtl/obbsat_mac.sv
// Shared signed multiplier with a dot-product and a radius accumulator.
`default_nettype none
module obbsat_mac
   import obbsat_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic signed [MUL_A_W-1:0]  mul_a,
   input  wire logic signed [MUL_B_W-1:0]  mul_b,
   input  wire mac_ctrl_type               ctrl,
   output logic signed [PROD_W-1:0]        product,
   output logic [MAG_W-1:0]                dot_mag,
   output logic [RAD_W-1:0]                rad_sum
);

   logic signed [DOT_W-1:0] dot_ff;
   logic signed [DOT_W-1:0] dot_in;
   logic [RAD_W-1:0]        rad_ff;
   logic [RAD_W-1:0]        rad_in;
   logic signed [DOT_W-1:0] dot_abs;

   // Multiply once per cycle
   assign product = mul_a * mul_b;

   // Load or accumulate the two running sums
   always_comb begin
      dot_in = dot_ff;
      rad_in = rad_ff;
      if (ctrl.dot_load) begin
         dot_in = product[DOT_W-1:0];
      end else if (ctrl.dot_add) begin
         dot_in = dot_ff + product[DOT_W-1:0];
      end
      if (ctrl.rad_load) begin
         rad_in = product[RAD_W-1:0];
      end else if (ctrl.rad_add) begin
         rad_in = rad_ff + product[RAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dot_ff <= dot_in;
      rad_ff <= rad_in;
   end

   // Magnitude of the finished dot product
   assign dot_abs = dot_ff[DOT_W-1] ? -dot_ff : dot_ff;
   assign dot_mag = dot_abs[MAG_W-1:0];
   assign rad_sum = rad_ff;

endmodule
`default_nettype wire

// File: rtl/obb_2d_separating_axis_test.sv
// Top level of the 2D oriented-box separating-axis overlap test.
`default_nettype none
// A load request stores its box as the reference and returns nothing. A test
// request returns one collides flag for the reference box against the request's
// box. A disabled test box answers 0. An enabled test first forms the box's
// scaled half extents, then runs up to four axes through one shared 33x29
// multiplier and its two accumulators: four axis dot products, four radius
// terms, the center projection and a compare. A failing axis ends the test
// early. The request port is ready only while the sequencer is idle; a
// finished response waits in the output register, and a new request may be
// taken meanwhile.
module obb_2d_separating_axis_test
   import obbsat_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_command,
   input  wire logic                     req_enabled,
   input  wire logic signed [POS_W-1:0]  req_pos_x,
   input  wire logic signed [POS_W-1:0]  req_pos_y,
   input  wire logic signed [AXIS_W-1:0] req_right_x,
   input  wire logic signed [AXIS_W-1:0] req_right_y,
   input  wire logic signed [AXIS_W-1:0] req_up_x,
   input  wire logic signed [AXIS_W-1:0] req_up_y,
   input  wire logic [SIZE_W-1:0]        req_box_width,
   input  wire logic [SIZE_W-1:0]        req_box_height,
   input  wire logic [SCL_W-1:0]         req_scale_x,
   input  wire logic [SCL_W-1:0]         req_scale_y,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_collides
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIZE_W,
      ST_SIZE_H,
      ST_AXIS,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      SQ_RR_X, SQ_RR_Y, SQ_RR_MUL,
      SQ_RU_X, SQ_RU_Y, SQ_RU_MUL,
      SQ_IR_X, SQ_IR_Y, SQ_IR_MUL,
      SQ_IU_X, SQ_IU_Y, SQ_IU_MUL,
      SQ_D_X,  SQ_D_Y,  SQ_CMP
   } step_type;

   typedef enum logic [1:0] {
      AX_REF_RIGHT,
      AX_REF_UP,
      AX_ITEM_RIGHT,
      AX_ITEM_UP
   } axis_type;

   // Control registers
   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   axis_type  axis_ff, axis_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_collides_ff, rsp_collides_in;

   // Reference box
   logic signed [POS_W-1:0]  ref_px_ff, ref_px_in;
   logic signed [POS_W-1:0]  ref_py_ff, ref_py_in;
   logic signed [AXIS_W-1:0] ref_rx_ff, ref_rx_in;
   logic signed [AXIS_W-1:0] ref_ry_ff, ref_ry_in;
   logic signed [AXIS_W-1:0] ref_ux_ff, ref_ux_in;
   logic signed [AXIS_W-1:0] ref_uy_ff, ref_uy_in;
   logic [HALF_W-1:0]        ref_hw_ff, ref_hw_in;
   logic [HALF_W-1:0]        ref_hh_ff, ref_hh_in;

   // Request box under work
   logic                     cmd_ff, cmd_in;
   logic                     hit_ff, hit_in;
   logic signed [POS_W-1:0]  i_px_ff, i_px_in;
   logic signed [POS_W-1:0]  i_py_ff, i_py_in;
   logic signed [AXIS_W-1:0] i_rx_ff, i_rx_in;
   logic signed [AXIS_W-1:0] i_ry_ff, i_ry_in;
   logic signed [AXIS_W-1:0] i_ux_ff, i_ux_in;
   logic signed [AXIS_W-1:0] i_uy_ff, i_uy_in;
   logic [SIZE_W-1:0]        i_bw_ff, i_bw_in;
   logic [SIZE_W-1:0]        i_bh_ff, i_bh_in;
   logic [SCL_W-1:0]         i_sx_ff, i_sx_in;
   logic [SCL_W-1:0]         i_sy_ff, i_sy_in;
   logic [HALF_W-1:0]        i_hw_ff, i_hw_in;
   logic [HALF_W-1:0]        i_hh_ff, i_hh_in;
   logic signed [DIFF_W-1:0] ddx_ff, ddx_in;
   logic signed [DIFF_W-1:0] ddy_ff, ddy_in;

   // Multiply unit hookup
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   mac_ctrl_type              mac_ctrl;
   logic signed [PROD_W-1:0]  product;
   logic [MAG_W-1:0]          dot_mag;
   logic [RAD_W-1:0]          rad_sum;
   logic [RAD_W-1:0]          center_dist;
   logic signed [AXIS_W-1:0]  ax;
   logic signed [AXIS_W-1:0]  ay;

   obbsat_mac u_mac (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .ctrl    (mac_ctrl),
      .product (product),
      .dot_mag (dot_mag),
      .rad_sum (rad_sum)
   );

   // Pick the current separating axis
   always_comb begin
      case (axis_ff)
         AX_REF_RIGHT:  begin ax = ref_rx_ff; ay = ref_ry_ff; end
         AX_REF_UP:     begin ax = ref_ux_ff; ay = ref_uy_ff; end
         AX_ITEM_RIGHT: begin ax = i_rx_ff;   ay = i_ry_ff;   end
         AX_ITEM_UP:    begin ax = i_ux_ff;   ay = i_uy_ff;   end
         default:       begin ax = i_ux_ff;   ay = i_uy_ff;   end
      endcase
   end

   // Projected center distance in the radius format
   assign center_dist = RAD_W'({dot_mag, {SHIFT_W{1'b0}}});

   // Sequence the shared multiplier and the request flow
   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      axis_in         = axis_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_collides_in = rsp_collides_ff;
      ref_px_in = ref_px_ff;
      ref_py_in = ref_py_ff;
      ref_rx_in = ref_rx_ff;
      ref_ry_in = ref_ry_ff;
      ref_ux_in = ref_ux_ff;
      ref_uy_in = ref_uy_ff;
      ref_hw_in = ref_hw_ff;
      ref_hh_in = ref_hh_ff;
      cmd_in  = cmd_ff;
      hit_in  = hit_ff;
      i_px_in = i_px_ff;
      i_py_in = i_py_ff;
      i_rx_in = i_rx_ff;
      i_ry_in = i_ry_ff;
      i_ux_in = i_ux_ff;
      i_uy_in = i_uy_ff;
      i_bw_in = i_bw_ff;
      i_bh_in = i_bh_ff;
      i_sx_in = i_sx_ff;
      i_sy_in = i_sy_ff;
      i_hw_in = i_hw_ff;
      i_hh_in = i_hh_ff;
      ddx_in  = ddx_ff;
      ddy_in  = ddy_ff;
      mul_a    = '0;
      mul_b    = '0;
      mac_ctrl = '0;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_command;
               i_px_in = req_pos_x;
               i_py_in = req_pos_y;
               i_rx_in = req_right_x;
               i_ry_in = req_right_y;
               i_ux_in = req_up_x;
               i_uy_in = req_up_y;
               i_bw_in = req_box_width;
               i_bh_in = req_box_height;
               i_sx_in = req_scale_x;
               i_sy_in = req_scale_y;
               ddx_in  = DIFF_W'(req_pos_x) - DIFF_W'(ref_px_ff);
               ddy_in  = DIFF_W'(req_pos_y) - DIFF_W'(ref_py_ff);
               if (req_command == CMD_TEST && !req_enabled) begin
                  hit_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SIZE_W;
               end
            end
         end

         ST_SIZE_W: begin
            mul_a    = MUL_A_W'(i_bw_ff);
            mul_b    = MUL_B_W'(i_sx_ff);
            i_hw_in  = product[HALF_W-1:0];
            state_in = ST_SIZE_H;
         end

         ST_SIZE_H: begin
            mul_a   = MUL_A_W'(i_bh_ff);
            mul_b   = MUL_B_W'(i_sy_ff);
            i_hh_in = product[HALF_W-1:0];
            if (cmd_ff == CMD_LOAD) begin
               ref_px_in = i_px_ff;
               ref_py_in = i_py_ff;
               ref_rx_in = i_rx_ff;
               ref_ry_in = i_ry_ff;
               ref_ux_in = i_ux_ff;
               ref_uy_in = i_uy_ff;
               ref_hw_in = i_hw_ff;
               ref_hh_in = product[HALF_W-1:0];
               state_in  = ST_IDLE;
            end else begin
               step_in  = SQ_RR_X;
               axis_in  = AX_REF_RIGHT;
               state_in = ST_AXIS;
            end
         end

         ST_AXIS: begin
            step_in = step_type'(step_ff + 4'd1);
            case (step_ff)
               SQ_RR_X: begin
                  mul_a = MUL_A_W'(ref_rx_ff);
                  mul_b = MUL_B_W'(ax);
                  mac_ctrl.dot_load = 1'b1;
               end
               SQ_RR_Y: begin
                  mul_a = MUL_A_W'(ref_ry_ff);
                  mul_b = MUL_B_W'(ay);
                  mac_ctrl.dot_add = 1'b1;
               end
               SQ_RR_MUL: begin
                  mul_a = MUL_A_W'(dot_mag[31:0]);
                  mul_b = MUL_B_W'(ref_hw_ff);
                  mac_ctrl.rad_load = 1'b1;
               end
               SQ_RU_X: begin
                  mul_a = MUL_A_W'(ref_ux_ff);
                  mul_b = MUL_B_W'(ax);
                  mac_ctrl.dot_load = 1'b1;
               end
               SQ_RU_Y: begin
                  mul_a = MUL_A_W'(ref_uy_ff);
                  mul_b = MUL_B_W'(ay);
                  mac_ctrl.dot_add = 1'b1;
               end
               SQ_RU_MUL: begin
                  mul_a = MUL_A_W'(dot_mag[31:0]);
                  mul_b = MUL_B_W'(ref_hh_ff);
                  mac_ctrl.rad_add = 1'b1;
               end
               SQ_IR_X: begin
                  mul_a = MUL_A_W'(i_rx_ff);
                  mul_b = MUL_B_W'(ax);
                  mac_ctrl.dot_load = 1'b1;
               end
               SQ_IR_Y: begin
                  mul_a = MUL_A_W'(i_ry_ff);
                  mul_b = MUL_B_W'(ay);
                  mac_ctrl.dot_add = 1'b1;
               end
               SQ_IR_MUL: begin
                  mul_a = MUL_A_W'(dot_mag[31:0]);
                  mul_b = MUL_B_W'(i_hw_ff);
                  mac_ctrl.rad_add = 1'b1;
               end
               SQ_IU_X: begin
                  mul_a = MUL_A_W'(i_ux_ff);
                  mul_b = MUL_B_W'(ax);
                  mac_ctrl.dot_load = 1'b1;
               end
               SQ_IU_Y: begin
                  mul_a = MUL_A_W'(i_uy_ff);
                  mul_b = MUL_B_W'(ay);
                  mac_ctrl.dot_add = 1'b1;
               end
               SQ_IU_MUL: begin
                  mul_a = MUL_A_W'(dot_mag[31:0]);
                  mul_b = MUL_B_W'(i_hh_ff);
                  mac_ctrl.rad_add = 1'b1;
               end
               SQ_D_X: begin
                  mul_a = MUL_A_W'(ddx_ff);
                  mul_b = MUL_B_W'(ax);
                  mac_ctrl.dot_load = 1'b1;
               end
               SQ_D_Y: begin
                  mul_a = MUL_A_W'(ddy_ff);
                  mul_b = MUL_B_W'(ay);
                  mac_ctrl.dot_add = 1'b1;
               end
               SQ_CMP: begin
                  // Stop on the first separating axis
                  if (!(center_dist < rad_sum)) begin
                     hit_in   = 1'b0;
                     state_in = ST_DONE;
                  end else if (axis_ff == AX_ITEM_UP) begin
                     hit_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     axis_in = axis_type'(axis_ff + 2'd1);
                     step_in = SQ_RR_X;
                  end
               end
               default: begin
                  step_in  = SQ_RR_X;
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_collides_in = hit_ff;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, response and reference box
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= SQ_RR_X;
         axis_ff         <= AX_REF_RIGHT;
         rsp_valid_ff    <= 1'b0;
         rsp_collides_ff <= 1'b0;
         ref_px_ff       <= '0;
         ref_py_ff       <= '0;
         ref_rx_ff       <= '0;
         ref_ry_ff       <= '0;
         ref_ux_ff       <= '0;
         ref_uy_ff       <= '0;
         ref_hw_ff       <= '0;
         ref_hh_ff       <= '0;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         axis_ff         <= axis_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_collides_ff <= rsp_collides_in;
         ref_px_ff       <= ref_px_in;
         ref_py_ff       <= ref_py_in;
         ref_rx_ff       <= ref_rx_in;
         ref_ry_ff       <= ref_ry_in;
         ref_ux_ff       <= ref_ux_in;
         ref_uy_ff       <= ref_uy_in;
         ref_hw_ff       <= ref_hw_in;
         ref_hh_ff       <= ref_hh_in;
      end
   end

   // Request payload under work
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      hit_ff  <= hit_in;
      i_px_ff <= i_px_in;
      i_py_ff <= i_py_in;
      i_rx_ff <= i_rx_in;
      i_ry_ff <= i_ry_in;
      i_ux_ff <= i_ux_in;
      i_uy_ff <= i_uy_in;
      i_bw_ff <= i_bw_in;
      i_bh_ff <= i_bh_in;
      i_sx_ff <= i_sx_in;
      i_sy_ff <= i_sy_in;
      i_hw_ff <= i_hw_in;
      i_hh_ff <= i_hh_in;
      ddx_ff  <= ddx_in;
      ddy_ff  <= ddy_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_collides = rsp_collides_ff;

endmodule
`default_nettype wire

// File: rtl/obbsat_checker.sv
// Port-level assertions for the separating-axis test, bound to the top level.
`default_nettype none
module obbsat_checker
   import obbsat_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_command,
   input wire logic req_enabled,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_collides
);

   // Leave reset idle with no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // Go busy after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request port ready right after a request");

   // Answer a disabled test box with a miss
   a_disabled_miss: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_TEST && !req_enabled && !rsp_valid)
      |-> ##2 (rsp_valid && !rsp_collides))
      else $error("disabled test box not answered with a miss");

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_collides)))
      else $error("stalled response changed");

endmodule

bind obb_2d_separating_axis_test obbsat_checker u_obbsat_checker (.*);
`default_nettype wire
